// File: hdl/mbad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbad_pkg
// shared types and codes of the mirrored bus address decoder
// ----------------------------------------------------------------------------
package mbad_pkg;

  // transaction kinds
  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_UNREG  = 2'd1;
  localparam logic [1:0] KIND_SINGLE = 2'd2;
  localparam logic [1:0] KIND_PAIR   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNMAPPED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_OVERLAP  = 3'd3;
  localparam logic [2:0] ST_PAST_END = 3'd4;

  // bus geometry
  localparam logic [15:0] PAGE_MASK = 16'hFF00;
  localparam logic [16:0] BUS_SIZE  = 17'h10000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  device_id;
    logic [15:0] base_addr;
    logic [16:0] device_size;
    logic [7:0]  mirror_count;
    logic        relative_addressing;
    logic [15:0] bus_addr;
    logic        is_write;
    logic [7:0]  write_byte;
    logic        wrap_bug;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  target_device;
    logic [15:0] device_addr;
    logic        access_write;
    logic [7:0]  data_out;
    logic        byte_select;
    logic        last;
  } out_item_t;

  // one window of the table, lim is the inclusive last address
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] lim;
    logic [16:0] size;
    logic        rel;
    logic [3:0]  id;
  } win_entry_t;

  typedef struct packed {
    logic shift;
    logic take_head;
    logic take_new;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_POST,
    S_DIV,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: hdl/mbad_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbad_in_if
// request channel of the decoder: valid, ready and one request item
// ----------------------------------------------------------------------------
interface mbad_in_if;
  logic                valid;
  logic                ready;
  mbad_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/mbad_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbad_out_if
// result channel of the decoder: valid, ready and one result item
// ----------------------------------------------------------------------------
interface mbad_out_if;
  logic                valid;
  logic                ready;
  mbad_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/mbad_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbad_cell
// one window slot of the table row; loads a new window or shifts toward the head
// ----------------------------------------------------------------------------
module mbad_cell (
  input  wire logic                 clk,
  input  wire mbad_pkg::cell_ctl_t  ctl,
  input  wire mbad_pkg::win_entry_t neighbor,
  input  wire mbad_pkg::win_entry_t head,
  input  wire mbad_pkg::win_entry_t fresh,
  output mbad_pkg::win_entry_t      entry
);

  mbad_pkg::win_entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      entry_r <= fresh;
    end else if (ctl.shift) begin
      // tail of the live region takes the entry leaving the head
      entry_r <= ctl.take_head ? head : neighbor;
    end
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

// File: hdl/mbad_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbad_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module mbad_rem (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [15:0]      rem
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  bits_r;
  logic [15:0] rem_r;
  logic [15:0] dvd_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic [15:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[15]};
  assign diff    = trial - divisor;
  assign rem_nxt = (trial >= divisor) ? diff[15:0] : trial[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bits_r == 4'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= 16'd0;
      dvd_r  <= dividend;
      bits_r <= 4'd15;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[14:0], 1'b0};
      bits_r <= bits_r - 4'd1;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: hdl/mirrored_bus_address_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mirrored_bus_address_decoder_unit
// 16-bit bus decoder with a table of mirrored device windows
// ----------------------------------------------------------------------------
// Takes one transaction at a time. The window table is a row of cells that
// hold the live windows packed at the front; every lookup, overlap check and
// unregister rotates the live windows once through the head cell, one window
// per cycle. A hit in a relative window whose offset lies in a mirror copy
// also runs the bit-serial remainder unit. A two-byte access runs the lookup
// twice and gives two results, low byte first. A finished result sits in an
// output register, so the next transaction is taken while it waits. Register
// windows end inclusively at base + size*(mirror+1) - 1 and are refused when
// the table is full, when the size is zero or above the bus size, when they
// run past the top of the bus or when they share an address with any live
// window. Unregister drops every window of the device id.
// ----------------------------------------------------------------------------
module mirrored_bus_address_decoder_unit #(
  parameter int MAX_WINDOWS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mbad_in_if.sink     in_ch,
  mbad_out_if.source  out_ch
);

  localparam int CW = $clog2(MAX_WINDOWS + 1);

  mbad_pkg::state_t     state_r, state_nxt;
  mbad_pkg::in_item_t   item_r;
  mbad_pkg::win_entry_t hit_r;
  mbad_pkg::out_item_t  res_r;
  mbad_pkg::out_item_t  out_r;
  mbad_pkg::out_item_t  res_post;
  logic                 out_valid_r;

  logic [25:0]   prod_r;      // size * (mirror + 1)
  logic [15:0]   lim_r;       // last address of the window being added
  logic [CW-1:0] cnt_r;       // live windows
  logic [CW-1:0] steps_r;     // rotation steps left
  logic [15:0]   qaddr_r;     // address being looked up
  logic          hi_phase_r;  // high byte of a two-byte access
  logic          found_r;
  logic          overlap_r;

  // table row
  mbad_pkg::win_entry_t cell_q [MAX_WINDOWS];
  mbad_pkg::cell_ctl_t  cell_ctl [MAX_WINDOWS];
  mbad_pkg::win_entry_t head;
  mbad_pkg::win_entry_t new_entry;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic          is_lookup;
  logic          scan_step;
  logic          head_hit;
  logic          head_ovl;
  logic          head_drop;
  logic [8:0]    mir_plus;
  logic [25:0]   reg_sum;
  logic [25:0]   lim_full;
  logic          size_bad;
  logic          past_end;
  logic          table_full;
  logic [15:0]   offset;
  logic          need_div;
  logic          append;
  logic          div_start;
  logic          rem_done;
  logic [15:0]   rem_q;
  logic [15:0]   hi_addr;
  logic [7:0]    lo_inc;

  // handshake
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = (state_r == mbad_pkg::S_EMIT) && out_free;
  assign in_ch.ready  = (state_r == mbad_pkg::S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_r;

  assign is_lookup = (item_r.kind == mbad_pkg::KIND_SINGLE) ||
                     (item_r.kind == mbad_pkg::KIND_PAIR);

  // window end arithmetic, product registered at accept
  assign mir_plus   = {1'b0, in_ch.payload.mirror_count} + 9'd1;
  assign reg_sum    = {10'd0, item_r.base_addr} + prod_r;
  assign lim_full   = reg_sum - 26'd1;
  assign size_bad   = (item_r.device_size == 17'd0) ||
                      (item_r.device_size > mbad_pkg::BUS_SIZE);
  assign past_end   = size_bad || (reg_sum > {9'd0, mbad_pkg::BUS_SIZE});
  assign table_full = (cnt_r >= CW'(MAX_WINDOWS));

  // head cell comparisons during a rotation
  assign head      = cell_q[0];
  assign scan_step = (state_r == mbad_pkg::S_SCAN) && (steps_r != '0);
  assign head_hit  = (head.base <= qaddr_r) && (qaddr_r <= head.lim);
  assign head_ovl  = (item_r.base_addr <= head.lim) && (head.base <= lim_r);
  assign head_drop = (item_r.kind == mbad_pkg::KIND_UNREG) &&
                     (head.id == item_r.device_id);

  // translation of a hit
  assign offset   = qaddr_r - hit_r.base;
  assign need_div = ({1'b0, offset} >= hit_r.size);

  // high byte address of a two-byte access
  assign lo_inc  = qaddr_r[7:0] + 8'd1;
  assign hi_addr = item_r.wrap_bug ? ((qaddr_r & mbad_pkg::PAGE_MASK) | {8'h00, lo_inc})
                                   : (qaddr_r + 16'd1);

  assign new_entry = '{base: item_r.base_addr, lim: lim_r, size: item_r.device_size,
                       rel: item_r.relative_addressing, id: item_r.device_id};

  assign append    = (state_r == mbad_pkg::S_POST) &&
                     (item_r.kind == mbad_pkg::KIND_REG) && !overlap_r;
  assign div_start = (state_r == mbad_pkg::S_POST) && is_lookup && found_r &&
                     hit_r.rel && need_div;

  // cell enables: rotate the live region, refill the tail from the head, append new windows
  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    assign cell_ctl[i].shift     = scan_step;
    assign cell_ctl[i].take_head = scan_step && !head_drop &&
                                   (CW'(i) == cnt_r - CW'(1));
    assign cell_ctl[i].take_new  = append && (CW'(i) == cnt_r);

    if (i == MAX_WINDOWS - 1) begin : g_tail
      mbad_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .neighbor (cell_q[i]),
        .head     (head),
        .fresh    (new_entry),
        .entry    (cell_q[i])
      );
    end else begin : g_body
      mbad_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .neighbor (cell_q[i+1]),
        .head     (head),
        .fresh    (new_entry),
        .entry    (cell_q[i])
      );
    end
  end

  mbad_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (offset),
    .divisor  (hit_r.size),
    .done     (rem_done),
    .rem      (rem_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbad_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.payload.kind == mbad_pkg::KIND_REG) ? mbad_pkg::S_CHECK
                                                                 : mbad_pkg::S_SCAN;
        end
      end
      mbad_pkg::S_CHECK: begin
        state_nxt = (table_full || past_end) ? mbad_pkg::S_EMIT : mbad_pkg::S_SCAN;
      end
      mbad_pkg::S_SCAN: begin
        if (steps_r == '0) begin
          state_nxt = mbad_pkg::S_POST;
        end
      end
      mbad_pkg::S_POST: begin
        state_nxt = div_start ? mbad_pkg::S_DIV : mbad_pkg::S_EMIT;
      end
      mbad_pkg::S_DIV: begin
        if (rem_done) begin
          state_nxt = mbad_pkg::S_EMIT;
        end
      end
      mbad_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = (item_r.kind == mbad_pkg::KIND_PAIR && !hi_phase_r) ? mbad_pkg::S_SCAN
                                                                          : mbad_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mbad_pkg::S_IDLE;
      end
    endcase
  end

  // result once the scan is over
  always_comb begin
    res_post = '0;
    res_post.last = 1'b1;
    case (item_r.kind)
      mbad_pkg::KIND_REG: begin
        res_post.status        = overlap_r ? mbad_pkg::ST_OVERLAP : mbad_pkg::ST_OK;
        res_post.target_device = item_r.device_id;
      end
      mbad_pkg::KIND_UNREG: begin
        res_post.status        = mbad_pkg::ST_OK;
        res_post.target_device = item_r.device_id;
      end
      mbad_pkg::KIND_SINGLE, mbad_pkg::KIND_PAIR: begin
        res_post.byte_select = hi_phase_r;
        res_post.last        = !(item_r.kind == mbad_pkg::KIND_PAIR && !hi_phase_r);
        if (found_r) begin
          res_post.status        = mbad_pkg::ST_OK;
          res_post.target_device = hit_r.id;
          res_post.device_addr   = hit_r.rel ? offset : qaddr_r;
          if (item_r.kind == mbad_pkg::KIND_SINGLE) begin
            res_post.access_write = item_r.is_write;
            res_post.data_out     = item_r.is_write ? item_r.write_byte : 8'h00;
          end
        end else begin
          res_post.status = mbad_pkg::ST_UNMAPPED;
        end
      end
      default: begin
        res_post.status = mbad_pkg::ST_OK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbad_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (scan_step && head_drop) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (append) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= in_ch.payload;
      prod_r     <= 26'(in_ch.payload.device_size) * 26'(mir_plus);
      steps_r    <= cnt_r;
      qaddr_r    <= in_ch.payload.bus_addr;
      hi_phase_r <= 1'b0;
      found_r    <= 1'b0;
      overlap_r  <= 1'b0;
    end

    if (state_r == mbad_pkg::S_CHECK) begin
      lim_r <= lim_full[15:0];
      res_r <= '{status: table_full ? mbad_pkg::ST_FULL : mbad_pkg::ST_PAST_END,
                 target_device: item_r.device_id, device_addr: 16'd0,
                 access_write: 1'b0, data_out: 8'h00, byte_select: 1'b0,
                 last: 1'b1};
    end

    if (scan_step) begin
      steps_r <= steps_r - CW'(1);
      if (is_lookup && !found_r && head_hit) begin
        found_r <= 1'b1;
        hit_r   <= head;
      end
      if (item_r.kind == mbad_pkg::KIND_REG && head_ovl) begin
        overlap_r <= 1'b1;
      end
    end

    if (state_r == mbad_pkg::S_POST) begin
      res_r <= res_post;
    end

    if (state_r == mbad_pkg::S_DIV && rem_done) begin
      res_r.device_addr <= rem_q;
    end

    if (out_load) begin
      out_r <= res_r;
      if (item_r.kind == mbad_pkg::KIND_PAIR && !hi_phase_r) begin
        hi_phase_r <= 1'b1;
        qaddr_r    <= hi_addr;
        steps_r    <= cnt_r;
        found_r    <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_WINDOWS))
    else $error("window count beyond table depth");

  a_steps_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbad_pkg::S_SCAN) |-> (steps_r <= cnt_r))
    else $error("rotation would visit slots outside the live region");

  a_unreg_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_step && item_r.kind == mbad_pkg::KIND_UNREG) |=> (cnt_r <= $past(cnt_r)))
    else $error("unregister grew the table");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbad_pkg::S_DIV && rem_done) |-> ({1'b0, rem_q} < hit_r.size))
    else $error("mirrored offset not reduced below device size");

  a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !res_r.last) |-> (item_r.kind == mbad_pkg::KIND_PAIR && !hi_phase_r))
    else $error("non-final result outside the low byte of a pair");
`endif

endmodule
`default_nettype wire

// File: bench/mbad_checker.sv
// ----------------------------------------------------------------------------
// mbad_checker
// watches both channels of the decoder, keeps its own copy of the window
// table, works out the results of every accepted request and compares them,
// in order, with the results the decoder hands out
// ----------------------------------------------------------------------------
module mbad_checker #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  mbad_in_if   in_mon,
  mbad_out_if  out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   hits,
  output int   misses,
  output int   refusals
);
  import mbad_pkg::*;

  typedef struct {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [16:0] dev_size;
    logic [7:0]  copies;
    logic        rel;
    logic [3:0]  owner;
  } window_t;

  window_t   windows [TABLE_DEPTH];
  int        live;
  out_item_t expected_q [$];

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                checked, name, got, want));
    end
  endtask

  // first live window holding the address wins
  function automatic out_item_t decode_lookup(logic [15:0] addr, logic wr,
                                              logic [7:0] data, logic sel,
                                              logic fin);
    out_item_t   res;
    int unsigned offset;
    res = '0;
    res.status = ST_UNMAPPED;
    res.byte_select = sel;
    res.last = fin;
    for (int i = 0; i < live; i++) begin
      if (windows[i].lo <= addr && addr <= windows[i].hi) begin
        offset = windows[i].rel ? addr - windows[i].lo : addr;
        if (windows[i].rel && windows[i].copies != 0 && offset >= windows[i].dev_size) begin
          offset = offset % windows[i].dev_size;
        end
        res.status = ST_OK;
        res.target_device = windows[i].owner;
        res.device_addr = offset[15:0];
        res.access_write = wr;
        res.data_out = wr ? data : 8'h00;
        return res;
      end
    end
    return res;
  endfunction

  task automatic queue_lookup(input out_item_t res);
    if (res.status == ST_OK) begin
      hits++;
    end else begin
      misses++;
    end
    expected_q.push_back(res);
  endtask

  task automatic predict_item(input in_item_t it);
    out_item_t   res;
    longint      span_end;
    logic [15:0] upper;
    logic        clash;
    int          i;
    res = '0;
    res.target_device = it.device_id;
    res.last = 1'b1;
    case (it.kind)
      KIND_REG: begin
        span_end = longint'(it.base_addr) +
                   longint'(it.device_size) * (longint'(it.mirror_count) + 1);
        if (live >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else if (it.device_size == 0 || it.device_size > BUS_SIZE ||
                     span_end > BUS_SIZE) begin
          res.status = ST_PAST_END;
        end else begin
          // inclusive ends on both sides
          upper = span_end - 1;
          clash = 1'b0;
          for (i = 0; i < live; i++) begin
            if (it.base_addr <= windows[i].hi && windows[i].lo <= upper) begin
              clash = 1'b1;
            end
          end
          if (clash) begin
            res.status = ST_OVERLAP;
          end else begin
            windows[live].lo = it.base_addr;
            windows[live].hi = upper;
            windows[live].dev_size = it.device_size;
            windows[live].copies = it.mirror_count;
            windows[live].rel = it.relative_addressing;
            windows[live].owner = it.device_id;
            live++;
            res.status = ST_OK;
          end
        end
        if (res.status != ST_OK) begin
          refusals++;
        end
        expected_q.push_back(res);
      end
      KIND_UNREG: begin
        // the last live window fills each hole
        i = 0;
        while (i < live) begin
          if (windows[i].owner == it.device_id) begin
            live--;
            if (i != live) begin
              windows[i] = windows[live];
            end
          end else begin
            i++;
          end
        end
        res.status = ST_OK;
        expected_q.push_back(res);
      end
      KIND_SINGLE: begin
        queue_lookup(decode_lookup(it.bus_addr, it.is_write, it.write_byte, 1'b0, 1'b1));
      end
      default: begin
        upper = it.wrap_bug ? ((it.bus_addr & PAGE_MASK) | ((it.bus_addr + 16'd1) & 16'h00FF))
                            : it.bus_addr + 16'd1;
        queue_lookup(decode_lookup(it.bus_addr, 1'b0, 8'h00, 1'b0, 1'b0));
        queue_lookup(decode_lookup(upper, 1'b0, 8'h00, 1'b1, 1'b1));
      end
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: status %0d device %0d addr 0x%0h",
                                got.status, got.target_device, got.device_addr));
    end else begin
      want = expected_q.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("target_device", got.target_device, want.target_device);
      compare_field("device_addr", got.device_addr, want.device_addr);
      compare_field("access_write", got.access_write, want.access_write);
      compare_field("data_out", got.data_out, want.data_out);
      compare_field("byte_select", got.byte_select, want.byte_select);
      compare_field("last", got.last, want.last);
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      live = 0;
      expected_q.delete();
      mismatches = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      refusals = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result(out_mon.payload);
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_item(in_mon.payload);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// File: bench/tb_mirrored_bus_address_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_mirrored_bus_address_decoder_unit
// drives the decoder with a directed run of window registrations, removals
// and one- and two-byte accesses, then a long random mix aimed mostly at
// recently tried windows; random gaps on both channels and long result
// stalls; the checker beside the decoder predicts and compares every result
// ----------------------------------------------------------------------------
module tb_mirrored_bus_address_decoder_unit;
  import mbad_pkg::*;

  localparam int TABLE_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 475;
  localparam int MAX_GAP      = 18;
  localparam int LONG_HOLD    = 300;
  localparam int RECENT_DEPTH = 12;
  localparam int DRAIN_CYCLES = 100;

  // a window the stimulus tried to register, used to aim accesses at it
  typedef struct {
    logic [15:0] base;
    int unsigned span;
    logic [3:0]  owner;
  } recent_win_t;

  logic clk = 1'b0;
  logic rst_n;

  mbad_in_if  in_bus ();
  mbad_out_if out_bus ();

  int mismatches;
  int outstanding;
  int checked;
  int hits;
  int misses;
  int refusals;

  int sent;
  int taken;
  int directed_count;

  recent_win_t recent_windows [$];
  in_item_t    directed_q [$];

  // 2 time unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mirrored_bus_address_decoder_unit #(
    .MAX_WINDOWS(TABLE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  mbad_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked),
    .hits       (hits),
    .misses     (misses),
    .refusals   (refusals)
  );

  function automatic in_item_t make_item(logic [1:0] k, logic [3:0] id, logic [15:0] base,
                                         logic [16:0] sz, logic [7:0] mirror, logic rel,
                                         logic [15:0] addr, logic wr, logic [7:0] data,
                                         logic bug);
    in_item_t it;
    it.kind = k;
    it.device_id = id;
    it.base_addr = base;
    it.device_size = sz;
    it.mirror_count = mirror;
    it.relative_addressing = rel;
    it.bus_addr = addr;
    it.is_write = wr;
    it.write_byte = data;
    it.wrap_bug = bug;
    return it;
  endfunction

  // random transaction; fields a kind ignores stay random as noise
  function automatic in_item_t random_item();
    in_item_t    it;
    recent_win_t w;
    int unsigned roll;
    it = make_item($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    roll = $urandom_range(0, 99);
    if (roll < 22) begin
      it.kind = KIND_REG;
      // mostly small windows so the table churns, a few whole-bus and bad sizes
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        it.device_size = $urandom_range(1, 256);
      end else if (roll < 78) begin
        it.device_size = $urandom_range(257, 17'h3000);
      end else if (roll < 86) begin
        it.device_size = $urandom_range(17'h3001, 17'h10000);
      end else if (roll < 90) begin
        it.device_size = BUS_SIZE;
      end else if (roll < 94) begin
        it.device_size = '0;
      end else begin
        it.device_size = $urandom_range(17'h10001, 17'h1FFFF);
      end
      it.mirror_count = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 0) begin
        it.base_addr[7:0] = 8'h00;
      end
    end else if (roll < 30) begin
      it.kind = KIND_UNREG;
      if (recent_windows.size() > 0 && $urandom_range(0, 1) == 0) begin
        w = recent_windows[$urandom_range(0, recent_windows.size() - 1)];
        it.device_id = w.owner;
      end
    end else begin
      it.kind = (roll < 65) ? KIND_SINGLE : KIND_PAIR;
      // aim at the inside and the edges of windows tried recently
      if (recent_windows.size() > 0 && $urandom_range(0, 3) != 0) begin
        w = recent_windows[$urandom_range(0, recent_windows.size() - 1)];
        case ($urandom_range(0, 5))
          0:       it.bus_addr = w.base;
          1:       it.bus_addr = w.base + w.span - 1;
          2:       it.bus_addr = w.base - 1;
          3:       it.bus_addr = w.base + w.span;
          default: it.bus_addr = w.base + $urandom_range(0, w.span - 1);
        endcase
      end
      // page-end pairs exercise the wrap of the high byte
      if (it.kind == KIND_PAIR && $urandom_range(0, 3) == 0) begin
        it.bus_addr[7:0] = 8'hFF;
      end
    end
    return it;
  endfunction

  // offer one transaction after a random gap and wait for the handshake
  task automatic send_item(input in_item_t it);
    int          gap;
    recent_win_t w;
    // every fourth stretch of 40 transactions goes back to back
    gap = (((sent / 40) % 4) == 2) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.payload <= it;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
    if (it.kind == KIND_REG && it.device_size != 0 && it.device_size <= BUS_SIZE) begin
      w.base = it.base_addr;
      w.span = it.device_size * (it.mirror_count + 1);
      w.owner = it.device_id;
      recent_windows.push_back(w);
      if (recent_windows.size() > RECENT_DEPTH) begin
        void'(recent_windows.pop_front());
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bus, then removal of a device that was never there
    directed_q.push_back(make_item(KIND_SINGLE, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h0000, 1'b1, 8'hA5, 1'b0));
    directed_q.push_back(make_item(KIND_UNREG, 4'd15, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // 0x0000..0x03ff, four copies of 256 bytes
    directed_q.push_back(make_item(KIND_REG, 4'd1, 16'h0000, 17'h00100, 8'd3, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // touches only the last address of the first window
    directed_q.push_back(make_item(KIND_REG, 4'd2, 16'h03FF, 17'd1, 8'd0, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // oversized device
    directed_q.push_back(make_item(KIND_REG, 4'd2, 16'h2000, 17'h1FFFF, 8'd0, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // ends exactly at the top of the bus, pass-through addressing
    directed_q.push_back(make_item(KIND_REG, 4'd3, 16'hFFFF, 17'd1, 8'd0, 1'b0,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // the mirror copy runs past the top
    directed_q.push_back(make_item(KIND_REG, 4'd2, 16'hF000, 17'h01000, 8'd1, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // odd size with the most mirror copies
    directed_q.push_back(make_item(KIND_REG, 4'd4, 16'h8000, 17'd3, 8'd255, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // whole bus fits the bounds but collides
    directed_q.push_back(make_item(KIND_REG, 4'd5, 16'h0000, 17'h10000, 8'd0, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // accesses into mirror copies, the top address and both data extremes
    directed_q.push_back(make_item(KIND_SINGLE, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h0250, 1'b1, 8'hFF, 1'b0));
    directed_q.push_back(make_item(KIND_SINGLE, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h82FF, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_SINGLE, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'hFFFF, 1'b1, 8'h5A, 1'b0));
    // two-byte accesses: page wrap, page carry, bus wrap, miss then hit
    directed_q.push_back(make_item(KIND_PAIR, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h00FF, 1'b1, 8'hFF, 1'b1));
    directed_q.push_back(make_item(KIND_PAIR, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h00FF, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_PAIR, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'hFFFF, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_PAIR, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h7FFF, 1'b0, 8'h00, 1'b0));
    // fill the table, device 6 owns two windows
    directed_q.push_back(make_item(KIND_REG, 4'd6, 16'h4000, 17'h00080, 8'd0, 1'b0,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_REG, 4'd6, 16'h5000, 17'h00010, 8'd15, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_REG, 4'd7, 16'h6000, 17'h00200, 8'd2, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_REG, 4'd8, 16'h9000, 17'd1, 8'd255, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_REG, 4'd9, 16'hA000, 17'h00800, 8'd0, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // full table is refused before the zero size is looked at
    directed_q.push_back(make_item(KIND_REG, 4'd10, 16'hC000, 17'd0, 8'd0, 1'b1,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    // removing both windows of device 6 moves entries from the back
    directed_q.push_back(make_item(KIND_UNREG, 4'd6, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_SINGLE, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h9005, 1'b1, 8'h3C, 1'b0));
    directed_q.push_back(make_item(KIND_UNREG, 4'd1, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h0000, 1'b0, 8'h00, 1'b0));
    directed_q.push_back(make_item(KIND_PAIR, 4'd0, 16'h0000, 17'd0, 8'd0, 1'b0,
                                   16'h00FF, 1'b0, 8'h00, 1'b0));
    directed_count = directed_q.size();

    foreach (directed_q[i]) begin
      send_item(directed_q[i]);
    end
    repeat (RANDOM_ITEMS) begin
      send_item(random_item());
    end
    in_bus.valid <= 1'b0;

    // let the checker see the last request, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // watch for stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d transactions (%0d directed), %0d results compared",
             sent, directed_count, checked);
    $display("lookups: %0d hits, %0d unmapped; %0d window registrations refused",
             hits, misses, refusals);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mirrored_bus_address_decoder_unit verification clean");
    end else begin
      $display("mirrored_bus_address_decoder_unit verification failed");
    end
    $finish;
  end

  // result side: random stalls, back-to-back stretches and two long hold-offs
  initial begin
    int hold;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 80 || taken == 520) begin
        // long hold-off, the decoder backs up and stalls its request side
        hold = LONG_HOLD;
      end else if (((taken / 64) % 4) == 1) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      taken++;
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("mirrored_bus_address_decoder_unit verification failed");
    $finish;
  end

endmodule
